/* design/rfa_pkg.sv */
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the rational fraction ALU: operation codes,
// field widths and stream word layout.
// ----------------------------------------------------------------------------
package rfa_pkg;

   localparam int FIELD_W     = 16;
   localparam int TYPE_W      = 3;
   localparam int NUM_W       = 33;
   localparam int DEN_W       = 32;
   localparam int REQ_TDATA_W = 4 * FIELD_W;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_PAD_W   = RSP_TDATA_W - NUM_W - DEN_W - 1;

   typedef enum logic [TYPE_W-1:0] {
      OP_ADD = 3'd0,
      OP_MUL = 3'd1,
      OP_INC = 3'd2,
      OP_RED = 3'd3,
      OP_CMP = 3'd4
   } op_type;

endpackage

/* design/rfa_mul.sv */
// ----------------------------------------------------------------------------
// rfa_mul
// Shared multiplier with a registered product.
// ----------------------------------------------------------------------------
module rfa_mul #(
   parameter int W = 16
) (
   input  logic           clock,
   input  logic [W-1:0]   mul_a,
   input  logic [W-1:0]   mul_b,
   output logic [2*W-1:0] prod_ff
);

   logic [2*W-1:0] prod_in;

   assign prod_in = (2*W)'(mul_a) * (2*W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* design/rfa_sub.sv */
// ----------------------------------------------------------------------------
// rfa_sub
// Shared subtract and compare unit for the GCD loop and the divider.
// ----------------------------------------------------------------------------
module rfa_sub #(
   parameter int SW = 34
) (
   input  logic [SW-1:0] sub_a,
   input  logic [SW-1:0] sub_b,
   output logic [SW-1:0] sub_diff,
   output logic          sub_borrow
);

   logic [SW:0] full;

   assign full       = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_diff   = full[SW-1:0];
   assign sub_borrow = full[SW];

endmodule

/* design/rational_fraction_alu_core.sv */
// ----------------------------------------------------------------------------
// rational_fraction_alu_core
// Rational number ALU: add, multiply, increment, reduce and compare on two
// fractions, every arithmetic result with nonzero fields reduced by its GCD.
//
//   channel  dir  tdata (low bit up)                   tuser
//   req_     in   a_num, a_den, b_num, b_den           req_type
//   rsp_     out  res_num, res_den, is_equal, zeros    -
//
// Compare and unused codes go straight to the output. Add and multiply first
// use the multiplier; then a zero check skips the reduction if a field is zero,
// else a binary GCD of one shift, swap or subtract per cycle, two restoring
// divisions of 2*OPERAND_WIDTH+1 quotient bits each, then one output.
// req_tready is high only in idle; a finished word waits in the output
// register while rsp_ stalls. Synchronous reset clears sequencer and rsp_tvalid.
// ----------------------------------------------------------------------------
module rational_fraction_alu_core
   import rfa_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // a_num, a_den, b_num, b_den
   input  logic [TYPE_W-1:0]      req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // res_num, res_den, is_equal, zeros
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int NW = 2 * W + 1;
   localparam int CW = $clog2(NW);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_CHK  = 6'b000100,
      ST_GCD  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [W-1:0]     an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [1:0]       step_ff, step_in;
   logic [NW-1:0]    num_ff, num_in, den_ff, den_in;
   logic [NW-1:0]    u_ff, u_in, v_ff, v_in, rem_ff, rem_in;
   logic [PW-1:0]    tmp_ff, tmp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             dsel_ff, dsel_in, eq_ff, eq_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [NUM_W-1:0] rsp_num_ff, rsp_num_in;
   logic [DEN_W-1:0] rsp_den_ff, rsp_den_in;
   logic             rsp_eq_ff, rsp_eq_in;

   logic [W-1:0]     p_an, p_ad, p_bn, p_bd;
   logic [W-1:0]     mul_a, mul_b;
   logic [PW-1:0]    prod_ff;
   logic [NW:0]      sub_a, sub_b, sub_diff;
   logic             sub_borrow;
   logic [NW-1:0]    dividend;
   logic             qbit;

   assign p_an = W'(req_tdata[FIELD_W-1:0]);
   assign p_ad = W'(req_tdata[2*FIELD_W-1:FIELD_W]);
   assign p_bn = W'(req_tdata[3*FIELD_W-1:2*FIELD_W]);
   assign p_bd = W'(req_tdata[4*FIELD_W-1:3*FIELD_W]);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_eq_ff, rsp_den_ff, rsp_num_ff};

   always_comb begin
      case (step_ff)
         2'd1: begin
            mul_a = (op_ff == OP_ADD) ? bd_ff : an_ff;
            mul_b = (op_ff == OP_ADD) ? an_ff : bn_ff;
         end
         2'd2: begin
            mul_a = ad_ff;
            mul_b = bn_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   rfa_mul #(.W(W)) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign dividend = dsel_ff ? den_ff : num_ff;

   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = {rem_ff, dividend[NW-1]};
         sub_b = {1'b0, u_ff};
      end else begin
         sub_a = {1'b0, u_ff};
         sub_b = {1'b0, v_ff};
      end
   end

   rfa_sub #(.SW(NW+1)) u_sub (
      .sub_a      (sub_a),
      .sub_b      (sub_b),
      .sub_diff   (sub_diff),
      .sub_borrow (sub_borrow)
   );

   assign qbit = ~sub_borrow;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      an_in         = an_ff;
      ad_in         = ad_ff;
      bn_in         = bn_ff;
      bd_in         = bd_ff;
      step_in       = step_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      rem_in        = rem_ff;
      tmp_in        = tmp_ff;
      cnt_in        = cnt_ff;
      dsel_in       = dsel_ff;
      eq_in         = eq_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_eq_in     = rsp_eq_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in   = op_type'(req_tuser);
               an_in   = p_an;
               ad_in   = p_ad;
               bn_in   = p_bn;
               bd_in   = p_bd;
               step_in = 2'd0;
               eq_in   = 1'b0;
               case (op_type'(req_tuser)) inside
                  OP_ADD, OP_MUL: begin
                     state_in = ST_MUL;
                  end
                  OP_INC: begin
                     num_in   = NW'(p_an) + NW'(p_ad);
                     den_in   = NW'(p_ad);
                     state_in = ST_CHK;
                  end
                  OP_RED: begin
                     num_in   = NW'(p_an);
                     den_in   = NW'(p_ad);
                     state_in = ST_CHK;
                  end
                  OP_CMP: begin
                     num_in   = '0;
                     den_in   = '0;
                     eq_in    = (p_an == p_bn) && (p_ad == p_bd);
                     state_in = ST_DONE;
                  end
                  default: begin
                     num_in   = '0;
                     den_in   = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd1: begin
                  den_in = NW'(prod_ff);
               end
               2'd2: begin
                  if (op_ff == OP_MUL) begin
                     num_in   = NW'(prod_ff);
                     state_in = ST_CHK;
                  end else begin
                     tmp_in = prod_ff;
                  end
               end
               2'd3: begin
                  num_in   = NW'(tmp_ff) + NW'(prod_ff);
                  state_in = ST_CHK;
               end
               default: begin
               end
            endcase
         end
         ST_CHK: begin
            if (num_ff == '0 || den_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               u_in     = num_ff;
               v_in     = den_ff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (v_ff == '0 || u_ff == '0) begin
               if (u_ff == '0) begin
                  u_in = v_ff;
               end
               rem_in   = '0;
               cnt_in   = '0;
               dsel_in  = 1'b0;
               state_in = ST_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in   = u_ff >> 1;
               v_in   = v_ff >> 1;
               num_in = num_ff >> 1;
               den_in = den_ff >> 1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (sub_borrow) begin
               u_in = v_ff;
               v_in = u_ff;
            end else begin
               u_in = sub_diff[NW-1:0];
            end
         end
         ST_DIV: begin
            rem_in = qbit ? sub_diff[NW-1:0] : sub_a[NW-1:0];
            if (dsel_ff) begin
               den_in = {den_ff[NW-2:0], qbit};
            end else begin
               num_in = {num_ff[NW-2:0], qbit};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW-1)) begin
               cnt_in = '0;
               if (dsel_ff) begin
                  state_in = ST_DONE;
               end else begin
                  dsel_in = 1'b1;
                  rem_in  = '0;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_num_in    = NUM_W'(num_ff);
               rsp_den_in    = DEN_W'(den_ff);
               rsp_eq_in     = eq_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      step_ff    <= step_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      rem_ff     <= rem_in;
      tmp_ff     <= tmp_in;
      cnt_ff     <= cnt_in;
      dsel_ff    <= dsel_in;
      eq_ff      <= eq_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_eq_ff  <= rsp_eq_in;
   end

endmodule

/* design/rfa_chk.sv */
// ----------------------------------------------------------------------------
// rfa_chk
// Port checker for the rational fraction ALU, bound to the top level.
// ----------------------------------------------------------------------------
module rfa_chk
   import rfa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req word taken while busy");

   a_cmp_zero_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[NUM_W+DEN_W] |-> rsp_tdata[NUM_W+DEN_W-1:0] == '0)
      else $error("compare word carries a fraction");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:NUM_W+DEN_W+1] == '0)
      else $error("rsp padding not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind rational_fraction_alu_core rfa_chk u_rfa_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
